### design/itaf_pkg.sv
package itaf_pkg;

    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int CHAR_W      = 7;
    localparam int NDIG        = 10;
    localparam int DIG_W       = NDIG * 4;
    localparam int IDX_W       = $clog2(NDIG);
    localparam int CNT_W       = $clog2(VAL_W);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_SDEC = 2'd0;
    localparam logic [OP_W-1:0] OP_UDEC = 2'd1;
    localparam logic [OP_W-1:0] OP_HEX  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
    localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

    typedef struct packed {
        logic             hex;
        logic             neg;
        logic [VAL_W-1:0] mag;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_EMIT
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] w;
        w = {3'b000, d};
        if (d < 4'd10) begin
            return CH_ZERO + w;
        end else begin
            return CH_UA + w - 7'd10;
        end
    endfunction

endpackage

### design/itaf_front.sv
module itaf_front
    import itaf_pkg::*;
(
    input  logic [OP_W-1:0]  i_opcode,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_valid,
    output logic             o_push,
    output t_entry           o_entry
);

    logic w_neg;

    // drop the unused opcode, split sign from magnitude
    assign w_neg         = (i_opcode == OP_SDEC) && i_value[VAL_W-1];
    assign o_push        = i_valid && ((i_opcode == OP_SDEC) || (i_opcode == OP_UDEC) ||
                                       (i_opcode == OP_HEX));
    assign o_entry.hex   = (i_opcode == OP_HEX);
    assign o_entry.neg   = w_neg;
    assign o_entry.mag   = w_neg ? (~i_value + VAL_W'(1)) : i_value;

endmodule

### design/itaf_queue.sv
module itaf_queue
    import itaf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            w_wr_en;
    logic            w_rd_en;

    assign o_full   = (r_cnt == CW'(DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_entry  = r_mem[r_rd];
    assign w_wr_en  = i_push && !o_full;
    assign w_rd_en  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_rd_en && !w_wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### design/itaf_back.sv
module itaf_back
    import itaf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_entry            i_q_entry,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_last
);

    t_state             r_state, n_state;
    logic [VAL_W-1:0]   r_bin, n_bin;
    logic [DIG_W-1:0]   r_dig, n_dig;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_hex, n_hex;
    logic [1:0]         r_pre, n_pre;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic               r_out_last, n_out_last;

    logic [DIG_W-1:0]   w_adj;
    logic [IDX_W-1:0]   w_top;
    logic               w_out_free;
    logic [3:0]         w_nib;
    logic [CHAR_W-1:0]  w_char;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_nib      = r_dig[{r_idx, 2'b00} +: 4];

    always_comb begin
        logic [3:0] v_nib;
        for (int i = 0; i < NDIG; i++) begin
            v_nib = r_dig[i*4 +: 4];
            w_adj[i*4 +: 4] = (v_nib >= 4'd5) ? v_nib + 4'd3 : v_nib;
        end
    end

    always_comb begin
        w_top = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (r_dig[i*4 +: 4] != 4'd0) begin
                w_top = IDX_W'(i);
            end
        end
    end

    always_comb begin
        if (r_pre != 2'd0) begin
            if (r_hex) begin
                w_char = (r_pre == 2'd2) ? CH_ZERO : CH_X;
            end else begin
                w_char = CH_MINUS;
            end
        end else begin
            w_char = digit_char(w_nib);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_dig      <= n_dig;
        r_cnt      <= n_cnt;
        r_hex      <= n_hex;
        r_pre      <= n_pre;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_dig       = r_dig;
        n_cnt       = r_cnt;
        n_hex       = r_hex;
        n_pre       = r_pre;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_q_pop = 1'b1;
                if (i_q_valid) begin
                    n_hex = i_q_entry.hex;
                    n_cnt = '0;
                    if (i_q_entry.hex) begin
                        n_dig   = {{(DIG_W-VAL_W){1'b0}}, i_q_entry.mag};
                        n_pre   = 2'd2;
                        n_state = ST_FIND;
                    end else begin
                        n_bin   = i_q_entry.mag;
                        n_dig   = '0;
                        n_pre   = i_q_entry.neg ? 2'd1 : 2'd0;
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                n_dig = {w_adj[DIG_W-2:0], r_bin[VAL_W-1]};
                n_bin = {r_bin[VAL_W-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VAL_W - 1)) begin
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                n_idx   = w_top;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = w_char;
                    n_out_last  = (r_pre == 2'd0) && (r_idx == '0);
                    if (r_pre != 2'd0) begin
                        n_pre = r_pre - 2'd1;
                    end else if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;

endmodule

### design/integer_to_ascii_formatter.sv
// Integer to ASCII formatter.
// Input channel (i_valid / o_stall) takes one beat of i_opcode and i_value:
// signed decimal, unsigned decimal, or hexadecimal with a 0x prefix. An
// unused opcode is taken and dropped without output.
// Output channel (o_valid / i_stall) gives one ASCII character per beat,
// most significant first, leading zeros suppressed, o_last on the final one.
// A front stage splits sign from magnitude and writes a small queue; the
// back end reads it, runs a 32-step shift-and-add-3 BCD conversion for
// decimal, finds the leading digit, then emits characters. An item gives
// at most 11 characters. While the back end works on one item, the queue
// takes up to QUEUE_DEPTH further items before o_stall rises.
// A stalled output holds its character; the back end waits and the queue
// fills. Synchronous reset empties the queue and drops any pending beat.
module integer_to_ascii_formatter
    import itaf_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_last
);

    logic   w_push;
    t_entry w_push_entry;
    logic   w_full;
    logic   w_pop;
    logic   w_q_valid;
    t_entry w_q_entry;

    itaf_front u_front (
        .i_opcode (i_opcode),
        .i_value  (i_value),
        .i_valid  (i_valid),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    itaf_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    itaf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_q_entry),
        .o_q_pop     (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    assign o_stall = w_full;

endmodule

### design/itaf_checker.sv
module itaf_checker
    import itaf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [CHAR_W-1:0] o_character,
    input logic              o_last
);

    logic [CHAR_W-1:0] r_prev_char;
    logic              r_prev_last;

    // track the last beat taken on the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_char <= CH_SPACE;
            r_prev_last <= 1'b1;
        end else if (o_valid && !i_stall) begin
            r_prev_char <= o_character;
            r_prev_last <= o_last;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_character) && $stable(o_last))
        else $error("output beat changed under stall");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_minus_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_character == CH_MINUS) |-> r_prev_last && !o_last)
        else $error("minus sign not at start of run");

    a_x_after_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_character == CH_X) |-> (r_prev_char == CH_ZERO) && !r_prev_last
                                             && !o_last)
        else $error("hex prefix out of order");

    a_lead_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_prev_char == CH_MINUS) && !r_prev_last
            |-> (o_character >= CH_ONE) && (o_character <= CH_NINE))
        else $error("leading digit after sign is not 1 to 9");

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_character (o_character),
    .o_last      (o_last)
);

### tb/integer_to_ascii_formatter_tb.sv
module integer_to_ascii_formatter_tb;
    import itaf_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [CHAR_W-1:0] ASC_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASC_UA    = 7'h41;
    localparam logic [CHAR_W-1:0] ASC_X     = 7'h78;
    localparam logic [CHAR_W-1:0] ASC_MINUS = 7'h2D;

    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [OP_W-1:0]   i_opcode;
    logic [VAL_W-1:0]  i_value;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [CHAR_W-1:0] o_character;
    logic              o_last;

    t_char_beat pending_chars[$];
    int         mismatches  = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         hold_reqs   = 0;
    int         hold_served = 0;
    int         hold_count  = 0;

    integer_to_ascii_formatter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void format_value(input logic [OP_W-1:0] op,
                                         input logic [VAL_W-1:0] val);
        logic [VAL_W-1:0]  mag;
        logic [CHAR_W-1:0] text[$];
        logic [CHAR_W-1:0] digits[$];
        logic [VAL_W-1:0]  radix;
        logic [3:0]        d;
        mag   = val;
        radix = 32'd10;
        case (op)
            OP_SDEC: begin
                if (val[VAL_W-1]) begin
                    text.push_back(ASC_MINUS);
                    mag = -val;
                end
            end
            OP_UDEC: begin
            end
            OP_HEX: begin
                text.push_back(ASC_ZERO);
                text.push_back(ASC_X);
                radix = 32'd16;
            end
            default: return;
        endcase
        do begin
            d = 4'(mag % radix);
            digits.push_front(d < 4'd10 ? ASC_ZERO + 7'(d) : ASC_UA + 7'(d) - 7'd10);
            mag = mag / radix;
        end while (mag != 0);
        foreach (digits[i]) text.push_back(digits[i]);
        foreach (text[i]) pending_chars.push_back('{ch: text[i], last: (i == text.size() - 1)});
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] p;
        p = 32'd1;
        case ($urandom_range(5))
            0, 1: return $urandom;
            2: return $urandom_range(0, 20);
            3: begin
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                return p - $urandom_range(0, 1);
            end
            4: return -($urandom_range(1, 1000));
            default: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
        endcase
    endfunction

    task automatic send_value(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        format_value(op, val);
    endtask

    task automatic test_directed();
        send_value(OP_SDEC, 32'h0000_0000);
        send_value(OP_SDEC, 32'h0000_0001);
        send_value(OP_SDEC, 32'hFFFF_FFFF);
        send_value(OP_SDEC, 32'h7FFF_FFFF);
        send_value(OP_SDEC, 32'h8000_0000);
        send_value(OP_SDEC, -32'd10);
        send_value(OP_UDEC, 32'd0);
        send_value(OP_UDEC, 32'd9);
        send_value(OP_UDEC, 32'd10);
        send_value(OP_UDEC, 32'd999_999_999);
        send_value(OP_UDEC, 32'd1_000_000_000);
        send_value(OP_UDEC, 32'hFFFF_FFFF);
        send_value(OP_UDEC, 32'h8000_0000);
        send_value(OP_HEX, 32'h0000_0000);
        send_value(OP_HEX, 32'h0000_000F);
        send_value(OP_HEX, 32'h0000_0010);
        send_value(OP_HEX, 32'h0FFF_FFFF);
        send_value(OP_HEX, 32'h1000_0000);
        send_value(OP_HEX, 32'hABCD_EF01);
        send_value(OP_HEX, 32'hFFFF_FFFF);
        send_value(OP_UNUSED, 32'h0000_0000);
        send_value(OP_UNUSED, 32'hFFFF_FFFF);
        send_value(OP_SDEC, 32'd2_147_483_647);
    endtask

    task automatic test_random(input int count);
        logic [OP_W-1:0] op;
        repeat (count) begin
            op = ($urandom_range(99) < 5) ? OP_UNUSED : OP_W'($urandom_range(0, 2));
            send_value(op, pick_value());
        end
    endtask

    task automatic test_output_hold();
        hold_reqs <= hold_reqs + 1;
        repeat (8) send_value(OP_W'($urandom_range(0, 2)), pick_value());
    endtask

    always @(posedge i_clk) begin
        if (hold_count != 0) begin
            hold_count <= hold_count - 1;
        end else if (hold_reqs != hold_served) begin
            hold_count  <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= (hold_count != 0) || ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected beat: expected none actual %h last %b",
                         $time, o_character, o_last);
                mismatches++;
            end else begin
                want = pending_chars.pop_front();
                if (o_character !== want.ch) begin
                    $display("%0t: character mismatch: expected %h actual %h",
                             $time, want.ch, o_character);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch: expected %b actual %b",
                             $time, want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_opcode = OP_SDEC;
        i_value  = '0;
        tx_idle_pct = 32;
        rx_idle_pct = 47;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(25);
        tx_idle_pct = 47;
        rx_idle_pct = 32;
        test_random(25);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_output_hold();
        test_random(20);
        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
